[sv/rasrc_pkg.sv]
package rasrc_pkg;

  // Stack geometry
  localparam int StackDepth = 16;
  localparam int CountWidth = 3;

  localparam int PtrW     = $clog2(StackDepth);
  localparam int RamAw    = PtrW + 1;          // {stack select, pointer}
  localparam int RamDepth = 2 ** RamAw;

  // Field widths on the stream ports
  localparam int AddrW     = 64;
  localparam int OpW       = 2;
  localparam int SizeW     = 4;
  localparam int PtrFieldW = 4;
  localparam int CntFieldW = 3;

  localparam int InFieldsW  = 3 + AddrW + SizeW + PtrFieldW + AddrW + CntFieldW;
  localparam int InDataW    = ((InFieldsW + 7) / 8) * 8;
  localparam int OutFieldsW = AddrW + PtrFieldW + CntFieldW;
  localparam int OutDataW   = ((OutFieldsW + 7) / 8) * 8;

  // Working widths wide enough for both the field and the internal value
  localparam int PtrExtW = (PtrW + 1 > PtrFieldW) ? PtrW + 1 : PtrFieldW;
  localparam int CntExtW = (CountWidth > CntFieldW) ? CountWidth : CntFieldW;

  localparam logic [AddrW-1:0]      ResetAddr = AddrW'(64'h8000_0000);
  localparam logic [CountWidth-1:0] MaxCount  = '1;
  localparam logic [PtrW-1:0]       LastPtr   = PtrW'(StackDepth - 1);

  typedef enum logic [OpW-1:0] {
    OP_PREDICT = 2'd0,
    OP_RECOVER = 2'd1,
    OP_COMMIT  = 2'd2
  } op_e;

  typedef enum logic {
    STK_SPEC   = 1'b0,
    STK_COMMIT = 1'b1
  } stack_e;

  typedef struct packed {
    logic [AddrW-1:0]      addr;
    logic [CountWidth-1:0] cnt;
  } entry_t;

  localparam entry_t ResetEntry = '{addr: ResetAddr, cnt: '0};

  // Input word layout, lowest field last
  typedef struct packed {
    logic [InDataW-InFieldsW-1:0] pad;
    logic [CntFieldW-1:0]         ckpt_top_count;
    logic [AddrW-1:0]             ckpt_top_addr;
    logic [PtrFieldW-1:0]         ckpt_pointer;
    logic [SizeW-1:0]             inst_size;
    logic [AddrW-1:0]             branch_pc;
    logic                         taken;
    logic                         is_return;
    logic                         is_call;
  } in_data_t;

  typedef struct packed {
    logic [OutDataW-OutFieldsW-1:0] pad;
    logic [CntFieldW-1:0]           snap_top_count;
    logic [PtrFieldW-1:0]           snap_pointer;
    logic [AddrW-1:0]               return_target;
  } out_data_t;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    return (p == LastPtr) ? '0 : PtrW'(p + 1'b1);
  endfunction

  function automatic logic [PtrW-1:0] ptr_dec(input logic [PtrW-1:0] p);
    return (p == '0) ? LastPtr : PtrW'(p - 1'b1);
  endfunction

  // Checkpoint pointer modulo the depth: a few compare and subtract steps
  function automatic logic [PtrW-1:0] ckpt_reduce(input logic [PtrFieldW-1:0] v);
    logic [PtrExtW-1:0] r;
    r = PtrExtW'(v);
    for (int k = 0; k < 8; k++) begin
      if (r >= PtrExtW'(StackDepth)) begin
        r = r - PtrExtW'(StackDepth);
      end
    end
    return r[PtrW-1:0];
  endfunction

endpackage

[sv/rasrc_ram.sv]
module rasrc_ram #(
  parameter  int Width = 8,
  parameter  int Depth = 16,
  localparam int Aw    = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [Aw-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [Aw-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[sv/return_address_stack_with_repeat_counter.sv]
// Return address stack with repeat counters, speculative and committed copies.
// The result word is registered; it loads in S_SNAP once the output is free.
// A new word is taken only in S_IDLE, after the snapshot read, checkpoint write
// on recover, and a read then write of the stack RAM for each push or pop.
// Reset (rst_ni low, asynchronous): both pointers to zero, every entry reads
// as address 0x80000000 with count zero until written; no clearing pass.
module return_address_stack_with_repeat_counter (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // is_call, is_return, taken, branch_pc, inst_size, ckpt_pointer,
  // ckpt_top_addr, ckpt_top_count, zero fill
  input  logic [rasrc_pkg::InDataW-1:0]  s_axis_tdata,
  // operation
  input  logic [rasrc_pkg::OpW-1:0]      s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // return_target, snap_pointer, snap_top_count, zero fill
  output logic [rasrc_pkg::OutDataW-1:0] m_axis_tdata
);

  import rasrc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,     // waiting for a word; snapshot read issued on accept
    S_SNAP,     // snapshot data back, hand it to the output register
    S_RESTORE,  // recover: write the checkpoint entry
    S_RD,       // read the top of the selected stack
    S_EX        // apply push or pop, write back
  } state_e;

  typedef enum logic [1:0] {
    PRIM_NONE,
    PRIM_PUSH,
    PRIM_POP
  } prim_e;

  state_e    state_q;
  in_data_t  in_w;
  op_e       in_op;
  logic      s_acc;

  // Per-word plan: optional checkpoint restore, then up to two stack steps
  stack_e    plan_sel;
  logic      plan_restore;
  prim_e     plan_slot0, plan_slot1;

  stack_e    sel_q;
  logic      restore_q;
  prim_e     slot0_q, slot1_q;
  logic      slot_q;

  logic [PtrW-1:0]       sp_q, cp_q;
  logic [AddrW-1:0]      ra_q;
  logic [PtrW-1:0]       ckpt_ptr_q;
  logic [AddrW-1:0]      ckpt_addr_q;
  logic [CountWidth-1:0] ckpt_cnt_q;
  logic [CntExtW-1:0]    ckpt_cnt_ext;

  // Valid bit per RAM entry stands in for the reset contents
  logic [RamDepth-1:0]   vld_q;
  logic                  rd_vld_q;

  logic                  ram_we, ram_re;
  logic [RamAw-1:0]      ram_waddr, ram_raddr;
  entry_t                ram_wdata;
  logic [$bits(entry_t)-1:0] ram_rdata;
  entry_t                rd_entry;

  logic [PtrW-1:0]       cur_ptr, ptr_nxt, ptr_prv, ex_ptr;
  prim_e                 cur_prim;
  logic                  push_hit;
  logic                  snap_load;

  logic                  out_valid_q;
  out_data_t             out_q;
  logic [PtrExtW-1:0]    snap_ptr_ext;
  logic [CntExtW-1:0]    snap_cnt_ext;

  assign in_w  = in_data_t'(s_axis_tdata);
  assign in_op = op_e'(s_axis_tuser);
  assign s_axis_tready = (state_q == S_IDLE);
  assign s_acc = s_axis_tvalid && s_axis_tready;

  assign ckpt_cnt_ext = CntExtW'(in_w.ckpt_top_count);

  // Decode the word into stack steps, in the order each operation wants
  always_comb begin
    plan_sel     = STK_SPEC;
    plan_restore = 1'b0;
    plan_slot0   = PRIM_NONE;
    plan_slot1   = PRIM_NONE;
    unique case (in_op)
      OP_PREDICT: begin
        plan_slot0 = in_w.is_call   ? PRIM_PUSH : PRIM_NONE;
        plan_slot1 = in_w.is_return ? PRIM_POP  : PRIM_NONE;
      end
      OP_RECOVER: begin
        // restore first, then pop before push
        plan_restore = 1'b1;
        plan_slot0   = (in_w.taken && in_w.is_return) ? PRIM_POP  : PRIM_NONE;
        plan_slot1   = (in_w.taken && in_w.is_call)   ? PRIM_PUSH : PRIM_NONE;
      end
      OP_COMMIT: begin
        plan_sel   = STK_COMMIT;
        plan_slot0 = (in_w.taken && in_w.is_call)   ? PRIM_PUSH : PRIM_NONE;
        plan_slot1 = (in_w.taken && in_w.is_return) ? PRIM_POP  : PRIM_NONE;
      end
      default: begin
        // unused code: result only, no state change
      end
    endcase
  end

  assign rd_entry = rd_vld_q ? entry_t'(ram_rdata) : ResetEntry;
  assign cur_ptr  = (sel_q == STK_COMMIT) ? cp_q : sp_q;
  assign cur_prim = slot_q ? slot1_q : slot0_q;
  assign ptr_nxt  = ptr_inc(cur_ptr);
  assign ptr_prv  = ptr_dec(cur_ptr);
  assign push_hit = (rd_entry.addr == ra_q) && (rd_entry.cnt != MaxCount);

  // Pointer after the current step
  always_comb begin
    ex_ptr = cur_ptr;
    unique case (cur_prim)
      PRIM_PUSH: ex_ptr = push_hit ? cur_ptr : ptr_nxt;
      PRIM_POP:  ex_ptr = (rd_entry.cnt != '0) ? cur_ptr : ptr_prv;
      default:   ex_ptr = cur_ptr;
    endcase
  end

  // RAM port control
  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = {STK_SPEC, sp_q};
    ram_we    = 1'b0;
    ram_waddr = {sel_q, cur_ptr};
    ram_wdata = rd_entry;
    unique case (state_q)
      S_IDLE: begin
        ram_re    = s_axis_tvalid;
        ram_raddr = {STK_SPEC, sp_q};
      end
      S_RD: begin
        ram_re    = 1'b1;
        ram_raddr = {sel_q, cur_ptr};
      end
      S_RESTORE: begin
        ram_we    = 1'b1;
        ram_waddr = {STK_SPEC, ckpt_ptr_q};
        ram_wdata = '{addr: ckpt_addr_q, cnt: ckpt_cnt_q};
      end
      S_EX: begin
        unique case (cur_prim)
          PRIM_PUSH: begin
            ram_we = 1'b1;
            if (push_hit) begin
              // same address on top: bump the repeat count
              ram_wdata = '{addr: rd_entry.addr, cnt: CountWidth'(rd_entry.cnt + 1'b1)};
            end else begin
              ram_waddr = {sel_q, ptr_nxt};
              ram_wdata = '{addr: ra_q, cnt: '0};
            end
          end
          PRIM_POP: begin
            // non-zero count: drop it; otherwise only the pointer moves
            ram_we    = (rd_entry.cnt != '0);
            ram_wdata = '{addr: rd_entry.addr, cnt: CountWidth'(rd_entry.cnt - 1'b1)};
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  rasrc_ram #(
    .Width ($bits(entry_t)),
    .Depth (RamDepth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign snap_load = (state_q == S_SNAP) && (!out_valid_q || m_axis_tready);

  // Sequencer, pointers, valid bits and output handshake
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      sp_q        <= '0;
      cp_q        <= '0;
      vld_q       <= '0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
      sel_q       <= STK_SPEC;
      restore_q   <= 1'b0;
      slot0_q     <= PRIM_NONE;
      slot1_q     <= PRIM_NONE;
      slot_q      <= 1'b0;
    end else begin
      if (ram_re) begin
        rd_vld_q <= vld_q[ram_raddr];
      end
      if (ram_we) begin
        vld_q[ram_waddr] <= 1'b1;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (s_acc) begin
            sel_q     <= plan_sel;
            restore_q <= plan_restore;
            slot0_q   <= plan_slot0;
            slot1_q   <= plan_slot1;
            state_q   <= S_SNAP;
          end
        end
        S_SNAP: begin
          if (snap_load) begin
            out_valid_q <= 1'b1;
            priority if (restore_q) begin
              state_q <= S_RESTORE;
            end else if (slot0_q != PRIM_NONE) begin
              slot_q  <= 1'b0;
              state_q <= S_RD;
            end else if (slot1_q != PRIM_NONE) begin
              slot_q  <= 1'b1;
              state_q <= S_RD;
            end else begin
              state_q <= S_IDLE;
            end
          end
        end
        S_RESTORE: begin
          sp_q <= ckpt_ptr_q;
          priority if (slot0_q != PRIM_NONE) begin
            slot_q  <= 1'b0;
            state_q <= S_RD;
          end else if (slot1_q != PRIM_NONE) begin
            slot_q  <= 1'b1;
            state_q <= S_RD;
          end else begin
            state_q <= S_IDLE;
          end
        end
        S_RD: begin
          state_q <= S_EX;
        end
        S_EX: begin
          if (sel_q == STK_COMMIT) begin
            cp_q <= ex_ptr;
          end else begin
            sp_q <= ex_ptr;
          end
          if (!slot_q && (slot1_q != PRIM_NONE)) begin
            slot_q  <= 1'b1;
            state_q <= S_RD;
          end else begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign snap_ptr_ext = PtrExtW'(sp_q);
  assign snap_cnt_ext = CntExtW'(rd_entry.cnt);

  // Word payload and result register
  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      ra_q        <= in_w.branch_pc + AddrW'(in_w.inst_size);
      ckpt_ptr_q  <= ckpt_reduce(in_w.ckpt_pointer);
      ckpt_addr_q <= in_w.ckpt_top_addr;
      ckpt_cnt_q  <= ckpt_cnt_ext[CountWidth-1:0];
    end
    if (snap_load) begin
      out_q.pad            <= '0;
      out_q.return_target  <= rd_entry.addr;
      out_q.snap_pointer   <= snap_ptr_ext[PtrFieldW-1:0];
      out_q.snap_top_count <= snap_cnt_ext[CntFieldW-1:0];
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

endmodule

[sv/rasrc_checker.sv]
module rasrc_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic [rasrc_pkg::InDataW-1:0]  s_axis_tdata,
  input logic [rasrc_pkg::OpW-1:0]      s_axis_tuser,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [rasrc_pkg::OutDataW-1:0] m_axis_tdata
);

  import rasrc_pkg::*;

  logic       s_acc, m_acc;
  logic [1:0] outst_q;

  assign s_acc = s_axis_tvalid && s_axis_tready;
  assign m_acc = m_axis_tvalid && m_axis_tready;

  // words taken but not yet answered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      outst_q <= '0;
    end else if (s_acc && !m_acc && (outst_q != 2'd3)) begin
      outst_q <= outst_q + 2'd1;
    end else if (m_acc && !s_acc && (outst_q != 2'd0)) begin
      outst_q <= outst_q - 2'd1;
    end
  end

  // At most one result held and one word in flight
  a_outst_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    outst_q != 2'd3)
    else $error("more than two words outstanding");

  // No result without a word behind it
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (outst_q != 2'd0))
    else $error("result without an accepted word");

  // One word at a time through the stack sequencer
  a_ready_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc |=> !s_axis_tready)
    else $error("input ready straight after an accepted word");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result changed");

endmodule

bind return_address_stack_with_repeat_counter rasrc_checker u_rasrc_checker (.*);

[bench/tb_return_address_stack_with_repeat_counter.sv]
`timescale 1ns / 100ps

module tb_return_address_stack_with_repeat_counter;
  import rasrc_pkg::*;

  // Unused operation code: the block must report a snapshot and change nothing
  localparam logic [OpW-1:0] OP_SPARE = 2'd3;

  // Shadow of both stacks. Each word accepted at the input is applied to the
  // shadow and the snapshot it must report (speculative top before acting)
  // is queued; words leaving the block are compared against that queue.
  class ras_shadow;
    logic [AddrW-1:0]      ra_tbl  [2][StackDepth];
    logic [CountWidth-1:0] rep_tbl [2][StackDepth];
    logic [PtrW-1:0]       top_ptr [2];
    out_data_t             due_snaps [$];  // snapshots still to come out
    out_data_t             recent [$];     // last 32, reused as checkpoints
    int                    errors;

    function new();
      errors = 0;
      for (int s = 0; s < 2; s++) begin
        top_ptr[s] = '0;
        for (int i = 0; i < StackDepth; i++) begin
          ra_tbl[s][i]  = ResetAddr;
          rep_tbl[s][i] = '0;
        end
      end
    endfunction

    function void push_ra(stack_e side, logic [AddrW-1:0] ra);
      int              s;
      logic [PtrW-1:0] p;
      s = int'(side);
      p = top_ptr[s];
      if (ra_tbl[s][p] == ra && rep_tbl[s][p] != MaxCount) begin
        rep_tbl[s][p] = rep_tbl[s][p] + 1'b1;   // recursion: same address again
      end else begin
        p = (int'(p) == StackDepth - 1) ? '0 : PtrW'(int'(p) + 1);
        ra_tbl[s][p]  = ra;
        rep_tbl[s][p] = '0;
        top_ptr[s]    = p;
      end
    endfunction

    function void pop_ra(stack_e side);
      int              s;
      logic [PtrW-1:0] p;
      s = int'(side);
      p = top_ptr[s];
      if (rep_tbl[s][p] != '0) begin
        rep_tbl[s][p] = rep_tbl[s][p] - 1'b1;
      end else begin
        top_ptr[s] = (p == '0) ? PtrW'(StackDepth - 1) : PtrW'(int'(p) - 1);
      end
    endfunction

    function void take_word(logic [OpW-1:0] op, in_data_t w);
      out_data_t        snap;
      logic [AddrW-1:0] ra;
      logic [PtrW-1:0]  sp;
      logic [PtrW-1:0]  cp;
      int               s;
      s  = int'(STK_SPEC);
      sp = top_ptr[s];
      snap = '0;
      snap.return_target  = ra_tbl[s][sp];
      snap.snap_pointer   = PtrFieldW'(sp);
      snap.snap_top_count = CntFieldW'(rep_tbl[s][sp]);
      due_snaps.push_back(snap);
      recent.push_back(snap);
      if (recent.size() > 32) void'(recent.pop_front());

      ra = w.branch_pc + AddrW'(w.inst_size);
      case (op)
        OP_PREDICT: begin
          if (w.is_call)   push_ra(STK_SPEC, ra);
          if (w.is_return) pop_ra(STK_SPEC);
        end
        OP_RECOVER: begin
          // restore the checkpoint first, then replay the resolved branch
          cp = PtrW'(int'(w.ckpt_pointer) % StackDepth);
          top_ptr[s]     = cp;
          ra_tbl[s][cp]  = w.ckpt_top_addr;
          rep_tbl[s][cp] = CountWidth'(w.ckpt_top_count);
          if (w.taken) begin
            if (w.is_return) pop_ra(STK_SPEC);
            if (w.is_call)   push_ra(STK_SPEC, ra);
          end
        end
        OP_COMMIT: begin
          if (w.taken) begin
            if (w.is_call)   push_ra(STK_COMMIT, ra);
            if (w.is_return) pop_ra(STK_COMMIT);
          end
        end
        default: ;
      endcase
    endfunction

    function void report(string what, logic [AddrW-1:0] want, logic [AddrW-1:0] got);
      errors++;
      if (errors <= 40)
        $display("%0t: %s mismatch, expected %h actual %h", $time, what, want, got);
    endfunction

    function void check_snapshot(out_data_t got);
      out_data_t want;
      if (due_snaps.size() == 0) begin
        errors++;
        if (errors <= 40)
          $display("%0t: unexpected output word, expected none actual %h", $time, got);
        return;
      end
      want = due_snaps.pop_front();
      if (got.return_target !== want.return_target)
        report("return_target", want.return_target, got.return_target);
      if (got.snap_pointer !== want.snap_pointer)
        report("snap_pointer", AddrW'(want.snap_pointer), AddrW'(got.snap_pointer));
      if (got.snap_top_count !== want.snap_top_count)
        report("snap_top_count", AddrW'(want.snap_top_count), AddrW'(got.snap_top_count));
    endfunction

    function int pending();
      return due_snaps.size();
    endfunction
  endclass

  // Clock, reset and every block input start at known values
  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  logic [OpW-1:0]      s_axis_tuser  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;

  ras_shadow        sb;
  int               idle_pct   = 0;   // chance of an idle burst, both sides
  int               stall_left = 0;
  int               busy_words = 0;   // words that actually move a stack
  logic [AddrW-1:0] pc_pool [8];

  return_address_stack_with_repeat_counter dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #10 clk_i = ~clk_i;

  function automatic logic [AddrW-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic rbit();
    return 1'($urandom_range(0, 1));
  endfunction

  function automatic in_data_t make_word(logic call, logic ret, logic tk,
                                         logic [AddrW-1:0] pc, logic [SizeW-1:0] sz,
                                         logic [PtrFieldW-1:0] cp,
                                         logic [AddrW-1:0] ca,
                                         logic [CntFieldW-1:0] cc);
    in_data_t w;
    w = '0;
    w.is_call        = call;
    w.is_return      = ret;
    w.taken          = tk;
    w.branch_pc      = pc;
    w.inst_size      = sz;
    w.ckpt_pointer   = cp;
    w.ckpt_top_addr  = ca;
    w.ckpt_top_count = cc;
    return w;
  endfunction

  // Random checkpoint fields for words that ignore them
  function automatic in_data_t predict_word(logic call, logic ret,
                                            logic [AddrW-1:0] pc, logic [SizeW-1:0] sz);
    return make_word(call, ret, rbit(), pc, sz, PtrFieldW'($urandom), rand64(),
                     CntFieldW'($urandom));
  endfunction

  // Mostly a small pool so that repeat counters get exercised
  function automatic logic [AddrW-1:0] pick_pc();
    if ($urandom_range(0, 9) < 7) return pc_pool[$urandom_range(0, 7)];
    return rand64();
  endfunction

  function automatic logic has_effect(logic [OpW-1:0] op, in_data_t w);
    case (op)
      OP_PREDICT: return w.is_call | w.is_return;
      OP_RECOVER: return 1'b1;
      OP_COMMIT:  return w.taken & (w.is_call | w.is_return);
      default:    return 1'b0;
    endcase
  endfunction

  // Present one word, optionally after an idle burst, and hold it until taken.
  // Entered and left at a rising edge.
  task automatic send_word(input logic [OpW-1:0] op, input in_data_t w);
    int gap;
    if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
      gap = $urandom_range(1, 4);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= w;
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.take_word(op, w);
    if (has_effect(op, w)) busy_words++;
  endtask

  // Random traffic: call and return bursts of one address (recursion),
  // recoveries mostly to checkpoints the block really reported, commits,
  // and a little noise.
  task automatic run_random(input int target);
    int               goal;
    int               kind;
    int               reps;
    logic [AddrW-1:0] pc;
    logic [SizeW-1:0] sz;
    out_data_t        snap;
    logic [PtrFieldW-1:0] cp;
    logic [AddrW-1:0]     ca;
    logic [CntFieldW-1:0] cc;
    goal = busy_words + target;
    while (busy_words < goal) begin
      kind = $urandom_range(0, 99);
      pc   = pick_pc();
      sz   = SizeW'($urandom_range(0, 15));
      if (kind < 35) begin
        reps = $urandom_range(1, 10);
        repeat (reps) send_word(OP_PREDICT, predict_word(1'b1, 1'b0, pc, sz));
      end else if (kind < 55) begin
        reps = $urandom_range(1, 10);
        repeat (reps) send_word(OP_PREDICT, predict_word(1'b0, 1'b1, pc, sz));
      end else if (kind < 63) begin
        send_word(OP_PREDICT, predict_word(rbit(), rbit(), pc, sz));
      end else if (kind < 80) begin
        if (sb.recent.size() > 0 && $urandom_range(0, 3) != 0) begin
          snap = sb.recent[$urandom_range(0, sb.recent.size() - 1)];
          cp = snap.snap_pointer;
          ca = snap.return_target;
          cc = snap.snap_top_count;
        end else begin
          cp = PtrFieldW'($urandom);
          ca = rand64();
          cc = CntFieldW'($urandom);
        end
        send_word(OP_RECOVER, make_word(rbit(), rbit(), 1'($urandom_range(0, 3) != 0),
                                        pc, sz, cp, ca, cc));
      end else if (kind < 95) begin
        send_word(OP_COMMIT, make_word(rbit(), rbit(), 1'($urandom_range(0, 6) != 0),
                                       pc, sz, PtrFieldW'($urandom), rand64(),
                                       CntFieldW'($urandom)));
      end else begin
        send_word(OpW'($urandom_range(0, 3)),
                  make_word(rbit(), rbit(), rbit(), rand64(), SizeW'($urandom),
                            PtrFieldW'($urandom), rand64(), CntFieldW'($urandom)));
      end
    end
  endtask

  // Output side: check every word taken, stall in random bursts
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_snapshot(m_axis_tdata);
    if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
      stall_left = $urandom_range(0, 3);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  initial begin
    sb = new();
    pc_pool[0] = '1;
    pc_pool[1] = '0;
    pc_pool[2] = 64'h7fff_ffff_ffff_fff8;
    pc_pool[3] = 64'h8000_0000 - 64'd4;   // lands on the reset address
    for (int i = 4; i < 8; i++) pc_pool[i] = rand64();

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part
    idle_pct = 25;
    send_word(OP_PREDICT, predict_word(1'b0, 1'b0, 64'h0, 4'd0));      // reset view
    send_word(OP_PREDICT, predict_word(1'b1, 1'b0, '1, 4'd15));        // address wraps
    // one new entry, seven counter steps to saturation, then a fresh entry
    repeat (9) send_word(OP_PREDICT, predict_word(1'b1, 1'b0, 64'h1000, 4'd4));
    send_word(OP_PREDICT, predict_word(1'b1, 1'b1, 64'h2000, 4'd2));   // call and return
    repeat (3) send_word(OP_PREDICT, predict_word(1'b0, 1'b1, 64'h0, 4'd0));
    send_word(OP_COMMIT, make_word(1'b1, 1'b0, 1'b1, '1, 4'd0, '1, '1, '1));
    send_word(OP_COMMIT, make_word(1'b0, 1'b1, 1'b1, 64'h0, 4'd0, '0, '0, '0));
    send_word(OP_COMMIT, make_word(1'b1, 1'b0, 1'b0, 64'h40, 4'd8, '0, '0, '0));
    send_word(OP_COMMIT, make_word(1'b1, 1'b1, 1'b1, 64'h80, 4'd1, '0, '0, '0));
    // checkpoint extremes, not taken
    send_word(OP_RECOVER, make_word(1'b1, 1'b1, 1'b0, '1, 4'd15, '1, '1, '1));
    // pop through a zero counter at pointer zero wraps to the last entry
    send_word(OP_RECOVER, make_word(1'b0, 1'b1, 1'b1, 64'h0, 4'd0, '0, '0, '0));
    send_word(OP_RECOVER, make_word(1'b1, 1'b1, 1'b1, 64'h3000, 4'd6, 4'd5,
                                    64'h3006, 3'd3));
    send_word(OP_SPARE, make_word(1'b1, 1'b1, 1'b1, '1, '1, '1, '1, '1));
    send_word(OP_PREDICT, predict_word(1'b0, 1'b1, 64'h0, 4'd0));
    send_word(OP_PREDICT, predict_word(1'b1, 1'b0, 64'h0, 4'd0));

    // Random part; the last stretch runs without idling
    idle_pct = 30;
    run_random(400);
    idle_pct = 0;
    run_random(300);
    idle_pct = 40;
    run_random(400);
    idle_pct = 15;
    run_random(300);
    idle_pct = 0;
    run_random(300);
    s_axis_tvalid <= 1'b0;

    while (sb.pending() > 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog, several times the slowest legal run
  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
